### src/bsva_pkg.sv
// Shared constants, types and codes for the block sparse vector accumulator.
`default_nettype none
package bsva_pkg;

   // table geometry
   localparam int CAPACITY        = 256;
   localparam int SLOT_BITS       = $clog2(CAPACITY);
   localparam int COUNT_BITS      = $clog2(CAPACITY + 1);
   localparam int MAX_BLOCK_WORDS = 16;
   localparam int ELEM_BITS       = $clog2(MAX_BLOCK_WORDS);
   localparam int KEY_BITS        = 24;
   localparam int VALUE_BITS      = 64;
   localparam int DIM_BITS        = 3;
   localparam int WADDR_BITS      = SLOT_BITS + ELEM_BITS;

   // stream word layout
   localparam int REQ_DATA_BITS = 96;
   localparam int RSP_DATA_BITS = 88;

   // result status codes
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_BAD_DIM   = 3'd2,
      STATUS_BAD_ELEM  = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   // item kinds
   typedef enum logic {
      KIND_ADD  = 1'b0,
      KIND_READ = 1'b1
   } kind_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_ZERO,
      S_WREAD,
      S_WUPD,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

### src/block_sparse_vector_accumulate.sv
// Top level: key search sequencer, block word store and saturating update.
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid / req_tready | tdata key, element, add_value; tuser kind
//  rsp     | out | rsp_tvalid / rsp_tready | tdata slot, found, status, value, count
//  csr     | in  | csr_wvalid / csr_wready | block_dim
//
// One item at a time; search compares one stored key a cycle. A hit reads the
// stored word and, for an add, writes the sum back; a read miss or a full table
// ends after the search; an insert appends the key, clears all 16 block words,
// then adds; a fault skips the search. The next word is taken in the cycle after
// the result leaves. Reset (synchronous) empties the table and sets block_dim to 1;
// RAMs are not cleared. A stalled result holds and no new word is taken until it leaves.
`default_nettype none
module block_sparse_vector_accumulate (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: key[23:0], element[27:24], add_value[91:28], zero pad
   input  wire logic [bsva_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // req_tuser: kind[0]
   input  wire logic [0:0]                          req_tuser,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // rsp_tdata: slot[7:0], found_existing[8], status[11:9],
   //            result_value[75:12], entries_used[84:76], zero pad
   output logic      [bsva_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // block_dim write
   input  wire logic [bsva_pkg::DIM_BITS-1:0]       csr_wdata,
   input  wire logic                                csr_wvalid,
   output logic                                     csr_wready
);

   localparam int SB = bsva_pkg::SLOT_BITS;
   localparam int CB = bsva_pkg::COUNT_BITS;
   localparam int EB = bsva_pkg::ELEM_BITS;
   localparam int KB = bsva_pkg::KEY_BITS;
   localparam int VB = bsva_pkg::VALUE_BITS;
   localparam int DB = bsva_pkg::DIM_BITS;
   localparam int AB = bsva_pkg::WADDR_BITS;
   localparam int RSP_USED = SB + 1 + 3 + VB + CB;

   bsva_pkg::state_type state_ff, state_in;

   logic [DB-1:0]          dim_ff;
   logic [CB-1:0]          count_ff, count_in;
   bsva_pkg::kind_type     kind_ff, kind_in;
   logic [KB-1:0]          key_ff, key_in;
   logic [EB-1:0]          elem_ff, elem_in;
   logic [VB-1:0]          addv_ff, addv_in;
   logic [CB-1:0]          rd_idx_ff, rd_idx_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [SB-1:0]          cmp_idx_ff, cmp_idx_in;
   logic [SB-1:0]          slot_ff, slot_in;
   logic                   found_ff, found_in;
   bsva_pkg::status_type   status_ff, status_in;
   logic [VB-1:0]          result_ff, result_in;
   logic [EB-1:0]          zero_ff, zero_in;

   logic                   req_accept;
   logic [EB:0]            elem_limit;
   logic                   bad_dim;
   logic                   bad_elem;
   logic [KB-1:0]          in_key;
   logic [EB-1:0]          in_elem;

   logic                   key_wr_en;
   logic                   key_rd_en;
   logic [KB-1:0]          key_rd;
   logic                   word_wr_en;
   logic [AB-1:0]          word_wr_addr;
   logic [VB-1:0]          word_wr_data;
   logic                   word_rd_en;
   logic [VB-1:0]          word_rd;
   logic [VB-1:0]          word_sum;

   logic                   hit;
   logic                   search_miss;
   logic                   issue;
   logic                   full;
   logic                   miss_done;

   assign in_key     = req_tdata[KB-1:0];
   assign in_elem    = req_tdata[KB+EB-1:KB];
   assign req_accept = req_tvalid && req_tready;
   assign csr_wready = 1'b1;

   // fault checks on the incoming word
   always_comb begin
      case (dim_ff)
         3'd1:    elem_limit = 5'd1;
         3'd2:    elem_limit = 5'd4;
         3'd3:    elem_limit = 5'd9;
         3'd4:    elem_limit = 5'd16;
         default: elem_limit = '0;
      endcase
      bad_dim  = (dim_ff < 3'd1) || (dim_ff > 3'd4);
      bad_elem = {1'b0, in_elem} >= elem_limit;
   end

   // search compare, one key per cycle
   assign hit         = cmp_vld_ff && (key_rd == key_ff);
   assign search_miss = (count_ff == '0) ||
                        (cmp_vld_ff && !hit &&
                         ((CB'(cmp_idx_ff) + 1'b1) == count_ff));
   assign issue       = rd_idx_ff < count_ff;
   assign full        = count_ff == CB'(bsva_pkg::CAPACITY);
   assign miss_done   = (kind_ff == bsva_pkg::KIND_READ) || full;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsva_pkg::S_IDLE: begin
            if (req_accept) begin
               state_in = (bad_dim || bad_elem) ? bsva_pkg::S_DONE : bsva_pkg::S_SEARCH;
            end
         end
         bsva_pkg::S_SEARCH: begin
            if (hit) begin
               state_in = bsva_pkg::S_WREAD;
            end else if (search_miss) begin
               state_in = miss_done ? bsva_pkg::S_DONE : bsva_pkg::S_ZERO;
            end
         end
         bsva_pkg::S_ZERO: begin
            if (zero_ff == '1) begin
               state_in = bsva_pkg::S_WREAD;
            end
         end
         bsva_pkg::S_WREAD: state_in = bsva_pkg::S_WUPD;
         bsva_pkg::S_WUPD:  state_in = bsva_pkg::S_DONE;
         bsva_pkg::S_DONE: begin
            if (rsp_tready) begin
               state_in = bsva_pkg::S_IDLE;
            end
         end
         default: state_in = bsva_pkg::S_IDLE;
      endcase
   end

   // outputs and memory strobes
   always_comb begin
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      key_rd_en    = 1'b0;
      key_wr_en    = 1'b0;
      word_wr_en   = 1'b0;
      word_rd_en   = 1'b0;
      word_wr_addr = {slot_ff, elem_ff};
      word_wr_data = word_sum;
      case (state_ff)
         bsva_pkg::S_IDLE:   req_tready = 1'b1;
         bsva_pkg::S_SEARCH: begin
            key_rd_en = 1'b1;
            key_wr_en = search_miss && !hit && !miss_done;
         end
         bsva_pkg::S_ZERO: begin
            word_wr_en   = 1'b1;
            word_wr_addr = {slot_ff, zero_ff};
            word_wr_data = '0;
         end
         bsva_pkg::S_WREAD:  word_rd_en = 1'b1;
         bsva_pkg::S_WUPD:   word_wr_en = (kind_ff == bsva_pkg::KIND_ADD);
         bsva_pkg::S_DONE:   rsp_tvalid = 1'b1;
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      count_in   = count_ff;
      kind_in    = kind_ff;
      key_in     = key_ff;
      elem_in    = elem_ff;
      addv_in    = addv_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      slot_in    = slot_ff;
      found_in   = found_ff;
      status_in  = status_ff;
      result_in  = result_ff;
      zero_in    = zero_ff;
      case (state_ff)
         bsva_pkg::S_IDLE: begin
            kind_in    = bsva_pkg::kind_type'(req_tuser[0]);
            key_in     = in_key;
            elem_in    = in_elem;
            addv_in    = req_tdata[KB+EB+VB-1:KB+EB];
            rd_idx_in  = '0;
            cmp_vld_in = 1'b0;
            cmp_idx_in = '0;
            slot_in    = '0;
            found_in   = 1'b0;
            result_in  = '0;
            zero_in    = '0;
            if (bad_dim) begin
               status_in = bsva_pkg::STATUS_BAD_DIM;
            end else if (bad_elem) begin
               status_in = bsva_pkg::STATUS_BAD_ELEM;
            end else begin
               status_in = bsva_pkg::STATUS_OK;
            end
         end
         bsva_pkg::S_SEARCH: begin
            cmp_vld_in = issue;
            cmp_idx_in = rd_idx_ff[SB-1:0];
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (hit) begin
               slot_in  = cmp_idx_ff;
               found_in = 1'b1;
            end else if (search_miss) begin
               if (kind_ff == bsva_pkg::KIND_READ) begin
                  status_in = bsva_pkg::STATUS_NOT_FOUND;
               end else if (full) begin
                  status_in = bsva_pkg::STATUS_FULL;
               end else begin
                  slot_in  = count_ff[SB-1:0];
                  count_in = count_ff + 1'b1;
                  zero_in  = '0;
               end
            end
         end
         bsva_pkg::S_ZERO: begin
            zero_in = zero_ff + 1'b1;
         end
         bsva_pkg::S_WUPD: begin
            result_in = (kind_ff == bsva_pkg::KIND_ADD) ? word_sum : word_rd;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bsva_pkg::S_IDLE;
         dim_ff     <= DB'(1);
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         if (csr_wvalid && csr_wready) begin
            dim_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      key_ff     <= key_in;
      elem_ff    <= elem_in;
      addv_ff    <= addv_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      slot_ff    <= slot_in;
      found_ff   <= found_in;
      status_ff  <= status_in;
      result_ff  <= result_in;
      zero_ff    <= zero_in;
   end

   // stored keys, one per slot
   bsva_ram #(
      .ADDR_BITS (SB),
      .DATA_BITS (KB)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (count_ff[SB-1:0]),
      .wr_data (key_ff),
      .rd_en   (key_rd_en),
      .rd_addr (rd_idx_ff[SB-1:0]),
      .rd_data (key_rd)
   );

   // block words, fixed stride per slot
   bsva_ram #(
      .ADDR_BITS (AB),
      .DATA_BITS (VB)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (word_wr_en),
      .wr_addr (word_wr_addr),
      .wr_data (word_wr_data),
      .rd_en   (word_rd_en),
      .rd_addr ({slot_ff, elem_ff}),
      .rd_data (word_rd)
   );

   // the one update unit
   bsva_sat_add u_sat_add (
      .a   (word_rd),
      .b   (addv_ff),
      .sum (word_sum)
   );

   assign rsp_tdata = {{(bsva_pkg::RSP_DATA_BITS - RSP_USED){1'b0}},
                       count_ff, result_ff, status_ff, found_ff, slot_ff};

endmodule
`default_nettype wire

### src/bsva_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bsva_ram #(
   parameter int ADDR_BITS = 8,
   parameter int DATA_BITS = 24
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### src/bsva_sat_add.sv
// Saturating signed Q32.32 adder shared by all add items.
`default_nettype none
module bsva_sat_add (
   input  wire logic [bsva_pkg::VALUE_BITS-1:0] a,
   input  wire logic [bsva_pkg::VALUE_BITS-1:0] b,
   output logic      [bsva_pkg::VALUE_BITS-1:0] sum
);

   localparam int MSB = bsva_pkg::VALUE_BITS - 1;

   logic [MSB:0] raw;
   logic         ovf;

   // overflow when operands agree in sign and the sum does not
   always_comb begin
      raw = a + b;
      ovf = ~(a[MSB] ^ b[MSB]) & (a[MSB] ^ raw[MSB]);
      if (ovf) begin
         sum = a[MSB] ? {1'b1, {MSB{1'b0}}} : {1'b0, {MSB{1'b1}}};
      end else begin
         sum = raw;
      end
   end

endmodule
`default_nettype wire
